### rtl/ps2_mouse_packet_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_DECODER_TOP_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset.
`define PS2MD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define PS2MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PS2MD_ASSERT(lbl, prop, msg)
`define PS2MD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/ps2md_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Shared widths, types, register indexes and packet bit positions.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  localparam int unsigned AxisW  = 12;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BtnW   = 3;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [AxisW-1:0] axis_t;
  typedef logic [SizeW-1:0] size_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [BtnW-1:0]  btn_t;

  // Largest screen dimension the cursor can address.
  localparam size_t MaxScreen = size_t'(4096);

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WHEEL_MODE    = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2
  } cfg_idx_e;

  // Bit positions in the first byte of a packet.
  localparam int unsigned SyncBit = 3;
  localparam int unsigned XOvfBit = 6;
  localparam int unsigned YOvfBit = 7;

  // Reset values.
  localparam size_t ResetWidth  = size_t'(1024);
  localparam size_t ResetHeight = size_t'(768);
  localparam axis_t ResetPosX   = axis_t'(200);
  localparam axis_t ResetPosY   = axis_t'(145);

endpackage

### rtl/ps2md_axis.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder axis update
// Applies a signed byte of motion to one cursor coordinate and clamps it.
// ----------------------------------------------------------------------------
module ps2md_axis import ps2md_pkg::*; (
  input  axis_t pos_i,
  input  byte_t delta_i,
  input  logic  negate_i,
  input  size_t size_i,
  output axis_t pos_o
);

  // Wide enough for 4095 + 128 and for 0 - 128.
  localparam int unsigned SumW = AxisW + 2;

  logic signed [SumW-1:0] pos_ext;
  logic signed [SumW-1:0] delta_ext;
  logic signed [SumW-1:0] sum;
  axis_t                  lim_m1;

  assign pos_ext   = $signed({2'b00, pos_i});
  assign delta_ext = $signed({{(SumW-ByteW){delta_i[ByteW-1]}}, delta_i});
  assign sum       = negate_i ? (pos_ext - delta_ext) : (pos_ext + delta_ext);

  // A zero size acts as one, anything beyond the largest screen as the largest.
  always_comb begin
    if (size_i == '0) begin
      lim_m1 = '0;
    end else if (size_i > MaxScreen) begin
      lim_m1 = axis_t'(MaxScreen - size_t'(1));
    end else begin
      lim_m1 = axis_t'(size_i - size_t'(1));
    end
  end

  always_comb begin
    if (sum[SumW-1]) begin
      pos_o = '0;
    end else if (sum > $signed({2'b00, lim_m1})) begin
      pos_o = lim_m1;
    end else begin
      pos_o = sum[AxisW-1:0];
    end
  end

endmodule

### rtl/ps2_mouse_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Assembles mouse bytes into packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+--------------------------------
//   in      | input     | in_valid_i/in_stall_o | rx_byte_i
//   out     | output    | out_valid_o/out_stall_i | cursor x/y, buttons, presses,
//           |           |                       | scroll up/down
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle while the input side is not stalled. A
// byte is held in the input register and the packet step runs between
// that register and the result register, so each result passes through both.
// Reset clears the byte position, the button history and the cursor to its
// home position; the packet store is not reset. A stalled result holds the
// result register, and the input register then holds its byte, stalling the
// input side only once both registers are full.
//
// A byte with the sync bit clear where a packet should start is discarded.
// A complete packet with an overflow flag produces no result and changes
// neither the cursor nor the button history.
module ps2_mouse_packet_decoder_top import ps2md_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,

  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  byte_t  rx_byte_i,

  output logic   out_valid_o,
  input  logic   out_stall_i,
  output axis_t  cursor_x_o,
  output axis_t  cursor_y_o,
  output btn_t   buttons_o,
  output logic   left_press_o,
  output logic   right_press_o,
  output logic   middle_press_o,
  output logic   scroll_up_o,
  output logic   scroll_down_o,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  size_t              cfg_data_i
);

  `include "ps2_mouse_packet_decoder_top_assert.svh"

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // --------------------------------------------------------------------------
  logic  wheel_mode_q;
  size_t screen_width_q;
  size_t screen_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q    <= 1'b0;
      screen_width_q  <= ResetWidth;
      screen_height_q <= ResetHeight;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WHEEL_MODE:    wheel_mode_q    <= cfg_data_i[0];
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. The step runs when the result register is free or its
  // item is being taken in this cycle.
  // --------------------------------------------------------------------------
  logic  in_valid_q;
  byte_t in_byte_q;
  logic  advance;
  logic  step;
  logic  in_load;

  assign advance    = !out_valid_o || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Packet framing. Bytes one to three of a packet are stored; the third is
  // also used straight from the input register when it completes a three-byte
  // packet, and the wheel byte is never stored.
  // --------------------------------------------------------------------------
  logic [1:0] byte_pos_q, byte_pos_d;
  byte_t      pkt0_q, pkt1_q, pkt2_q;
  btn_t       last_btn_q;
  axis_t      pos_x_q, pos_y_q;

  logic  sync_lost;
  logic  complete;
  logic  overflow;
  logic  emit;
  byte_t dy_byte;
  axis_t new_x, new_y;
  btn_t  now_btn;
  btn_t  rise_btn;

  assign sync_lost = (byte_pos_q == 2'd0) && !in_byte_q[SyncBit];
  // A packet ends when the next position reaches the packet size. After a
  // drop to three-byte mode at the fourth position, this byte also ends it.
  assign complete  = wheel_mode_q ? (byte_pos_q == 2'd3) : (byte_pos_q >= 2'd2);
  assign overflow  = pkt0_q[XOvfBit] || pkt0_q[YOvfBit];
  assign emit      = step && !sync_lost && complete && !overflow;
  assign dy_byte   = (byte_pos_q == 2'd2) ? in_byte_q : pkt2_q;
  assign now_btn   = pkt0_q[BtnW-1:0];
  assign rise_btn  = now_btn & ~last_btn_q;

  always_comb begin
    byte_pos_d = byte_pos_q;
    if (step && !sync_lost) begin
      byte_pos_d = complete ? 2'd0 : byte_pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && !sync_lost) begin
      case (byte_pos_q)
        2'd0:    pkt0_q <= in_byte_q;
        2'd1:    pkt1_q <= in_byte_q;
        2'd2:    pkt2_q <= in_byte_q;
        default: ;
      endcase
    end
  end

  ps2md_axis u_axis_x (
    .pos_i    (pos_x_q),
    .delta_i  (pkt1_q),
    .negate_i (1'b0),
    .size_i   (screen_width_q),
    .pos_o    (new_x)
  );

  // Mouse Y grows upward while the cursor row grows downward.
  ps2md_axis u_axis_y (
    .pos_i    (pos_y_q),
    .delta_i  (dy_byte),
    .negate_i (1'b1),
    .size_i   (screen_height_q),
    .pos_o    (new_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= 2'd0;
      pos_x_q    <= ResetPosX;
      pos_y_q    <= ResetPosY;
      last_btn_q <= '0;
    end else begin
      byte_pos_q <= byte_pos_d;
      if (emit) begin
        pos_x_q    <= new_x;
        pos_y_q    <= new_y;
        last_btn_q <= now_btn;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cursor_x_o     <= new_x;
      cursor_y_o     <= new_y;
      buttons_o      <= now_btn;
      left_press_o   <= rise_btn[0];
      right_press_o  <= rise_btn[1];
      middle_press_o <= rise_btn[2];
      // The wheel byte is the one completing a four-byte packet.
      scroll_up_o    <= wheel_mode_q && !in_byte_q[ByteW-1] && (in_byte_q != '0);
      scroll_down_o  <= wheel_mode_q && in_byte_q[ByteW-1];
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `PS2MD_ASSERT(a_stall_needs_item, !in_stall_o || in_valid_q, "input stalled while empty")
  `PS2MD_ASSERT_NEXT(a_sync_drop, step && sync_lost, !out_valid_o && $stable(byte_pos_q),
                     "discarded byte changed framing or made a result")
  `PS2MD_ASSERT_NEXT(a_emit_frame, emit, out_valid_o && (byte_pos_q == 2'd0),
                     "result without realigned framing")
  `PS2MD_ASSERT(a_scroll_excl, !out_valid_o || !(scroll_up_o && scroll_down_o),
                "scroll up and down together")

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder testbench
// Streams mouse bytes into the decoder under random idle and stall patterns,
// predicts every cursor report in a scoreboard and compares each field.
// ----------------------------------------------------------------------------
module tb_top;
  import ps2md_pkg::*;

  // One cursor report as the decoder presents it on its result channel.
  typedef struct packed {
    axis_t x;
    axis_t y;
    btn_t  btn;
    logic  left_press;
    logic  right_press;
    logic  middle_press;
    logic  scroll_up;
    logic  scroll_down;
  } cursor_report_t;

  // Scoreboard: tracks framing, cursor and button history exactly as the
  // decoder should, and keeps the cursor reports that are still owed.
  class cursor_scoreboard;
    logic           wheel_on;
    size_t          scr_w;
    size_t          scr_h;
    logic [1:0]     frame_pos;
    byte_t          held [3];
    axis_t          cur_x;
    axis_t          cur_y;
    btn_t           prev_btn;
    cursor_report_t expected_reports [$];
    int unsigned    reports_checked;
    int unsigned    mismatches;
    int unsigned    overflow_drops;
    int unsigned    resync_skips;

    function new();
      wheel_on        = 1'b0;
      scr_w           = ResetWidth;
      scr_h           = ResetHeight;
      frame_pos       = '0;
      cur_x           = ResetPosX;
      cur_y           = ResetPosY;
      prev_btn        = '0;
      reports_checked = 0;
      mismatches      = 0;
      overflow_drops  = 0;
      resync_skips    = 0;
      foreach (held[i]) held[i] = '0;
    endfunction

    function void set_register(cfg_idx_e idx, size_t val);
      case (idx)
        CFG_WHEEL_MODE:    wheel_on = val[0];
        CFG_SCREEN_WIDTH:  scr_w = val;
        CFG_SCREEN_HEIGHT: scr_h = val;
        default: ;
      endcase
    endfunction

    // A screen size of zero behaves as one, anything past the largest
    // addressable screen behaves as that screen.
    function axis_t limit_to_screen(int v, size_t size);
      int lim;
      lim = int'(size);
      if (lim == 0) lim = 1;
      if (lim > int'(MaxScreen)) lim = int'(MaxScreen);
      if (v < 0) return '0;
      if (v >= lim) return axis_t'(lim - 1);
      return axis_t'(v);
    endfunction

    function void accept_byte(byte_t b);
      int             pkt_len;
      int             nx;
      int             ny;
      btn_t           rise;
      cursor_report_t r;
      pkt_len = wheel_on ? 4 : 3;
      // Where a packet should start, a byte without the sync bit is dropped.
      if (frame_pos == 0 && !b[SyncBit]) begin
        resync_skips++;
        return;
      end
      if (frame_pos < 3) held[frame_pos] = b;
      if (int'(frame_pos) + 1 < pkt_len) begin
        frame_pos++;
        return;
      end
      frame_pos = '0;
      if (held[0][XOvfBit] || held[0][YOvfBit]) begin
        overflow_drops++;
        return;
      end
      nx    = int'(cur_x) + int'($signed(held[1]));
      ny    = int'(cur_y) - int'($signed(held[2]));
      cur_x = limit_to_screen(nx, scr_w);
      cur_y = limit_to_screen(ny, scr_h);
      r.btn = held[0][BtnW-1:0];
      rise  = r.btn & ~prev_btn;
      prev_btn = r.btn;
      r.x            = cur_x;
      r.y            = cur_y;
      r.left_press   = rise[0];
      r.right_press  = rise[1];
      r.middle_press = rise[2];
      // The wheel byte is the one that closes a four-byte packet.
      r.scroll_up    = wheel_on && (int'($signed(b)) > 0);
      r.scroll_down  = wheel_on && (int'($signed(b)) < 0);
      expected_reports.push_back(r);
    endfunction

    function void check_report(cursor_report_t got);
      cursor_report_t want;
      logic           bad;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: cursor report with none expected: x=%0d y=%0d btn=%03b",
                   $time, got.x, got.y, got.btn);
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      bad = (got.x !== want.x) || (got.y !== want.y) || (got.btn !== want.btn) ||
            (got.left_press !== want.left_press) ||
            (got.right_press !== want.right_press) ||
            (got.middle_press !== want.middle_press) ||
            (got.scroll_up !== want.scroll_up) || (got.scroll_down !== want.scroll_down);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR %0t: cursor report %0d differs", $time, reports_checked);
          $display("  expected x=%0d y=%0d btn=%03b press(l,r,m)=%b%b%b scroll(u,d)=%b%b",
                   want.x, want.y, want.btn, want.left_press, want.right_press,
                   want.middle_press, want.scroll_up, want.scroll_down);
          $display("  actual   x=%0d y=%0d btn=%03b press(l,r,m)=%b%b%b scroll(u,d)=%b%b",
                   got.x, got.y, got.btn, got.left_press, got.right_press,
                   got.middle_press, got.scroll_up, got.scroll_down);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction
  endclass

  // Roughly this many random bytes follow the directed opening.
  localparam int unsigned RandomBytes   = 1300;
  // A byte passes through the input register and the result register before
  // its result can be taken; leave some margin.
  localparam int unsigned SettleCycles  = 4;
  // Longest stretch without any handshake before the run is declared hung.
  localparam int unsigned WatchdogLimit = 2000;
  // Length of the long output hold-off that fills the decoder.
  localparam int unsigned LongHoldCycles = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  byte_t              rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  axis_t              cursor_x_o;
  axis_t              cursor_y_o;
  btn_t               buttons_o;
  logic               left_press_o;
  logic               right_press_o;
  logic               middle_press_o;
  logic               scroll_up_o;
  logic               scroll_down_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  size_t              cfg_data_i;

  cursor_scoreboard sb;

  // Sender state used by the driving tasks and the stimulus.
  logic        wheel_sel;
  logic        gaps_on;
  int unsigned burst_left;
  int unsigned bytes_offered;
  int unsigned phases_run;
  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int unsigned hold_requests = 0;

  ps2_mouse_packet_decoder_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cursor_x_o     (cursor_x_o),
    .cursor_y_o     (cursor_y_o),
    .buttons_o      (buttons_o),
    .left_press_o   (left_press_o),
    .right_press_o  (right_press_o),
    .middle_press_o (middle_press_o),
    .scroll_up_o    (scroll_up_o),
    .scroll_down_o  (scroll_down_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Present one byte and hold it until the decoder takes it. Valid is left
  // high so that a following byte goes out back to back.
  task automatic send_byte(input byte_t b);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.accept_byte(b);
    bytes_offered++;
  endtask

  // Send a byte as part of the current burst; when the burst runs out and
  // gaps are enabled, the sender goes quiet for a random number of cycles.
  // Burst lengths are random, so the gaps land at every byte position.
  task automatic offer(input byte_t b);
    send_byte(b);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Stop sending, wait for every owed report, then give the pipeline time
  // to finish a packet that produced no report (overflow or partial).
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the registers selected by mask in index order, keeping valid high
  // across the writes and lowering it after the last one.
  task automatic program_regs(input logic [2:0] mask, input logic wheel,
                              input size_t w, input size_t h);
    cfg_idx_e idx;
    size_t    val;
    for (int i = 0; i < 3; i++) begin
      if (mask[i]) begin
        idx = cfg_idx_e'(i);
        case (idx)
          CFG_WHEEL_MODE:   val = size_t'(wheel);
          CFG_SCREEN_WIDTH: val = w;
          default:          val = h;
        endcase
        cfg_valid_i <= 1'b1;
        cfg_index_i <= idx;
        cfg_data_i  <= val;
        do @(posedge clk_i); while (!cfg_ready_o);
        sb.set_register(idx, val);
      end
    end
    cfg_valid_i <= 1'b0;
    if (mask[CFG_WHEEL_MODE]) wheel_sel = wheel;
  endtask

  // Movement bytes lean toward the extremes so that clamping happens often.
  function automatic byte_t motion_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h7F;
      1:       return 8'h80;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // A well-formed packet for the current mode; about one in ten keeps random
  // overflow flags and is dropped if either is set.
  task automatic send_packet();
    byte_t head;
    int    len;
    len  = wheel_sel ? 4 : 3;
    head = byte_t'($urandom_range(0, 255));
    head[SyncBit] = 1'b1;
    if ($urandom_range(0, 9) != 0) begin
      head[XOvfBit] = 1'b0;
      head[YOvfBit] = 1'b0;
    end
    offer(head);
    for (int i = 1; i < len; i++) offer(motion_byte());
  endtask

  // Line noise: a stray byte without sync, any byte at all, or a packet cut
  // short so that the framing slips.
  task automatic send_noise();
    byte_t b;
    case ($urandom_range(0, 2))
      0: begin
        b = byte_t'($urandom_range(0, 255));
        b[SyncBit] = 1'b0;
        offer(b);
      end
      1: offer(byte_t'($urandom_range(0, 255)));
      default: begin
        b = byte_t'($urandom_range(0, 255));
        b[SyncBit] = 1'b1;
        offer(b);
        offer(motion_byte());
      end
    endcase
  endtask

  // Screen sizes: tiny screens where the cursor hits the walls, mostly the
  // whole legal span, and values past either end of it.
  function automatic size_t pick_size();
    case ($urandom_range(0, 7))
      0:       return size_t'($urandom_range(0, 8));
      1:       return size_t'($urandom_range(9, 300));
      2:       return size_t'($urandom_range(4097, 8191));
      3:       return MaxScreen;
      default: return size_t'($urandom_range(1, 4096));
    endcase
  endfunction

  // Receiver. Outside the long hold-off it switches between stall patterns
  // of random density, including stretches with no stalls at all. The long
  // hold-off is counted here, so the sender keeps offering bytes meanwhile.
  initial begin : receiver
    int unsigned holds_served;
    int unsigned hold_left;
    int unsigned pattern_left;
    int unsigned stall_pct;
    holds_served = 0;
    hold_left    = 0;
    pattern_left = 0;
    stall_pct    = 0;
    out_stall_i  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          pattern_left = $urandom_range(10, 150);
        end
        pattern_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Every accepted report goes to the scoreboard. Sampling at the edge sees
  // the values from before the edge, since all drivers update afterwards.
  always @(posedge clk_i) begin : report_monitor
    cursor_report_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.x            = cursor_x_o;
      seen.y            = cursor_y_o;
      seen.btn          = buttons_o;
      seen.left_press   = left_press_o;
      seen.right_press  = right_press_o;
      seen.middle_press = middle_press_o;
      seen.scroll_up    = scroll_up_o;
      seen.scroll_down  = scroll_down_o;
      sb.check_report(seen);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no handshake for %0d cycles, %0d reports still owed",
             WatchdogLimit, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main stimulus.
  initial begin : stimulus
    size_t corner_sizes [4];
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_WHEEL_MODE;
    cfg_data_i    = '0;
    wheel_sel     = 1'b0;
    gaps_on       = 1'b0;
    burst_left    = 1;
    bytes_offered = 0;
    phases_run    = 0;
    corner_sizes  = '{size_t'(0), MaxScreen, size_t'(8191), size_t'(2)};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening, at the reset settings (three-byte packets, 1024x768).
    // Bytes without sync where a packet should start must be skipped.
    offer(8'h00);
    offer(8'hF7);
    // Largest right move and largest downward move, no buttons.
    offer(8'h08); offer(8'h7F); offer(8'h80);
    // All three buttons pressed, largest left and upward move.
    offer(8'h0F); offer(8'h80); offer(8'h7F);
    // Overflow packets: both flags with every other bit set, then X alone.
    offer(8'hFF); offer(8'h00); offer(8'hFF);
    offer(8'h48); offer(8'h12); offer(8'h34);
    settle();

    // Wheel packets on a one-pixel screen: the cursor is pinned to the corner
    // and the wheel byte decides the scroll direction.
    program_regs(3'b111, 1'b1, size_t'(1), size_t'(1));
    offer(8'h09); offer(8'h01); offer(8'h01); offer(8'h7F);
    offer(8'h0A); offer(8'hFF); offer(8'hFF); offer(8'h80);
    // Three bytes of a wheel packet, then a drop to three-byte mode: the next
    // byte closes the packet and reports no scroll.
    offer(8'h0C); offer(8'h05); offer(8'h05);
    settle();
    program_regs(3'b001, 1'b0, size_t'(1), size_t'(1));
    offer(8'h00);

    // Random phases. Each one waits for the decoder to drain, picks new
    // settings and streams a mix of packets and noise. The first phases
    // walk through the screen-size corners.
    bytes_offered = 0;
    while (bytes_offered < RandomBytes) begin
      settle();
      if (phases_run < 4)
        program_regs(3'b111, logic'($urandom_range(0, 1)),
                     corner_sizes[phases_run], corner_sizes[3 - phases_run]);
      else
        program_regs(3'b111, logic'($urandom_range(0, 1)), pick_size(), pick_size());
      gaps_on = ($urandom_range(0, 3) != 0);

      if (phases_run == 2) begin
        // Long output hold-off while bytes keep coming back to back, so the
        // decoder fills up and pushes back on its input.
        hold_requests++;
        gaps_on = 1'b0;
        repeat (12) send_packet();
      end

      repeat ($urandom_range(15, 35)) begin
        if ($urandom_range(0, 99) < 85) send_packet();
        else send_noise();
      end

      // Sometimes stop mid-packet so the next settings, possibly a different
      // packet size, take effect inside a packet.
      if ($urandom_range(0, 1) != 0) begin
        offer(byte_t'($urandom_range(0, 255)) | 8'h08);
        repeat ($urandom_range(0, 2)) offer(motion_byte());
      end
      phases_run++;
    end

    settle();

    $display("Covered %0d random bytes over %0d setting phases: %0d reports checked,",
             bytes_offered, phases_run, sb.reports_checked);
    $display("%0d overflow packets dropped, %0d bytes skipped while hunting for sync.",
             sb.overflow_drops, sb.resync_skips);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d reports never arrived", sb.mismatches, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
